// File: design/gsa_pkg.sv
`default_nettype none

package gsa_pkg;

  // Default sizes of the slot table.
  localparam int unsigned SLOT_COUNT_DEF = 256;
  localparam int unsigned GEN_BITS_DEF   = 16;

  // Field widths of one beat on either side.
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ID_W     = 9;
  localparam int unsigned HGEN_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 48;

  // Requested operation.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 3'd0,
    ACT_DESTROY = 3'd1,
    ACT_CHECK   = 3'd2,
    ACT_ENQUEUE = 3'd3,
    ACT_DRAIN   = 3'd4
  } action_e;

  // Result status.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_DEAD  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_QFULL = 2'd3
  } status_e;

  // Per-slot state kept next to the generation.
  typedef enum logic [1:0] {
    SLOT_FREE   = 2'd0,
    SLOT_ALIVE  = 2'd1,
    SLOT_QUEUED = 2'd2
  } slot_state_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ALLOC_RD,
    S_DR_IDX,
    S_DR_SLOT
  } fsm_state_e;

endpackage

`default_nettype wire

// File: design/gsa_ram.sv
`default_nettype none

module gsa_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: design/generational_slot_allocator.sv
`default_nettype none

// Generational slot table: hands out handles (slot index plus one, generation) and
// checks, frees and batch-frees them. One command beat gives one result beat. Check,
// destroy, enqueue and an allocate that appends a fresh slot finish in the execute state;
// an allocate that reuses a freed slot reads the free stack and then the slot table in
// turn, each through a registered read port. A drain works through the queue entry by
// entry, with one read of the queue and, for an entry in the used range, one
// read-modify-write of the slot table. The slot table needs no clearing pass after reset: entries at or
// above the used-slot count are never used before they are written.
module generational_slot_allocator #(
  parameter int unsigned SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
  parameter int unsigned GEN_BITS   = gsa_pkg::GEN_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // action [2:0], handle_id [11:3], handle_generation [27:12]
  input  wire logic [gsa_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // status [1:0], out_handle_id [10:2], out_generation [26:11],
  // released_count [35:27], live_count [44:36]
  output logic      [gsa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SW = GEN_BITS + 2;
  localparam int unsigned LD = 2 * SLOT_COUNT;

  // Control registers.
  gsa_pkg::fsm_state_e state_q, state_d;
  gsa_pkg::action_e    act_q, act_d;
  logic [gsa_pkg::ID_W-1:0]   id_q, id_d;
  logic [gsa_pkg::HGEN_W-1:0] hgen_q, hgen_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] free_depth_q, free_depth_d;
  logic [CW-1:0] slots_used_q, slots_used_d;
  logic [CW-1:0] fifo_depth_q, fifo_depth_d;
  logic [CW-1:0] live_q, live_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] rel_q, rel_d;
  logic out_valid_q, out_valid_d;
  logic [gsa_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Memory ports.
  logic          slot_we, slot_re;
  logic [IW-1:0] slot_waddr, slot_raddr;
  logic [SW-1:0] slot_wdata, slot_rdata;
  logic          list_we, list_re;
  logic [IW:0]   list_waddr, list_raddr;
  logic [IW-1:0] list_wdata, list_rdata;

  // Decoded views.
  logic                       in_fire, out_free, fin, stall, step, do_free;
  gsa_pkg::action_e           in_act;
  logic [gsa_pkg::ID_W-1:0]   in_id;
  logic [IW-1:0]              in_idx, fd_m1;
  gsa_pkg::slot_state_e       rd_st;
  logic [GEN_BITS-1:0]        rd_gen, gen_next;
  logic                       id_ok, hit;
  gsa_pkg::status_e           res_status;
  logic [gsa_pkg::ID_W-1:0]   res_oid;
  logic [gsa_pkg::HGEN_W-1:0] res_ogen;

  // Slot table: {state, generation}.
  gsa_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (SW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (slot_we),
    .wr_addr_i (slot_waddr),
    .wr_data_i (slot_wdata),
    .rd_en_i   (slot_re),
    .rd_addr_i (slot_raddr),
    .rd_data_o (slot_rdata)
  );

  // Index lists: free stack in the lower half, destroy queue in the upper half.
  gsa_ram #(
    .DEPTH (LD),
    .WIDTH (IW)
  ) u_list_ram (
    .clk_i     (clk_i),
    .wr_en_i   (list_we),
    .wr_addr_i (list_waddr),
    .wr_data_i (list_wdata),
    .rd_en_i   (list_re),
    .rd_addr_i (list_raddr),
    .rd_data_o (list_rdata)
  );

  assign s_axis_tready_o = (state_q == gsa_pkg::S_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign in_act = gsa_pkg::action_e'(s_axis_tdata_i[2:0]);
  assign in_id  = s_axis_tdata_i[11:3];
  assign in_idx = IW'(32'(in_id) - 32'd1);
  assign fd_m1  = IW'(32'(free_depth_q) - 32'd1);

  assign rd_st  = gsa_pkg::slot_state_e'(slot_rdata[SW-1 -: 2]);
  assign rd_gen = slot_rdata[GEN_BITS-1:0];

  // Generation after a free skips zero on wrap.
  assign gen_next = (rd_gen == '1) ? GEN_BITS'(1) : rd_gen + GEN_BITS'(1);

  // A handle is alive when it names a used, non-free slot of the same generation.
  assign id_ok = (id_q != '0) && ((32'(id_q) - 32'd1) < 32'(slots_used_q));
  assign hit   = id_ok && (rd_st != gsa_pkg::SLOT_FREE) && (32'(rd_gen) == 32'(hgen_q));

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gsa_pkg::S_IDLE;
      free_depth_q <= '0;
      slots_used_q <= '0;
      fifo_depth_q <= '0;
      live_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_depth_q <= free_depth_d;
      slots_used_q <= slots_used_d;
      fifo_depth_q <= fifo_depth_d;
      live_q       <= live_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    id_q       <= id_d;
    hgen_q     <= hgen_d;
    idx_q      <= idx_d;
    k_q        <= k_d;
    rel_q      <= rel_d;
    out_data_q <= out_data_d;
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    id_d         = id_q;
    hgen_d       = hgen_q;
    idx_d        = idx_q;
    free_depth_d = free_depth_q;
    slots_used_d = slots_used_q;
    fifo_depth_d = fifo_depth_q;
    live_d       = live_q;
    k_d          = k_q;
    rel_d        = rel_q;
    slot_we      = 1'b0;
    slot_waddr   = idx_q;
    slot_wdata   = '0;
    slot_re      = 1'b0;
    slot_raddr   = idx_q;
    list_we      = 1'b0;
    list_waddr   = '0;
    list_wdata   = idx_q;
    list_re      = 1'b0;
    list_raddr   = '0;
    fin          = 1'b0;
    step         = 1'b0;
    do_free      = 1'b0;
    res_status   = gsa_pkg::STAT_OK;
    res_oid      = '0;
    res_ogen     = '0;

    unique case (state_q)
      gsa_pkg::S_IDLE: begin
        // Read the addressed slot and the list head the command will need.
        if (in_fire) begin
          act_d      = in_act;
          id_d       = in_id;
          hgen_d     = s_axis_tdata_i[27:12];
          idx_d      = in_idx;
          slot_re    = 1'b1;
          slot_raddr = in_idx;
          list_re    = 1'b1;
          list_raddr = (in_act == gsa_pkg::ACT_DRAIN) ? {1'b1, IW'(0)} : {1'b0, fd_m1};
          state_d    = gsa_pkg::S_EXEC;
        end
      end
      gsa_pkg::S_EXEC: begin
        case (act_q)
          gsa_pkg::ACT_ALLOC: begin
            if (free_depth_q != '0) begin
              // Reuse the most recently freed slot.
              free_depth_d = free_depth_q - CW'(1);
              idx_d        = list_rdata;
              slot_re      = 1'b1;
              slot_raddr   = list_rdata;
              state_d      = gsa_pkg::S_ALLOC_RD;
            end else if (32'(slots_used_q) < SLOT_COUNT) begin
              // Append a fresh slot with generation one.
              fin          = 1'b1;
              slot_we      = 1'b1;
              slot_waddr   = IW'(slots_used_q);
              slot_wdata   = {gsa_pkg::SLOT_ALIVE, GEN_BITS'(1)};
              slots_used_d = slots_used_q + CW'(1);
              live_d       = live_q + CW'(1);
              res_oid      = gsa_pkg::ID_W'(32'(slots_used_q) + 32'd1);
              res_ogen     = gsa_pkg::HGEN_W'(1);
            end else begin
              fin        = 1'b1;
              res_status = gsa_pkg::STAT_FULL;
            end
          end
          gsa_pkg::ACT_DESTROY: begin
            fin = 1'b1;
            if (!hit) begin
              res_status = gsa_pkg::STAT_DEAD;
            end else begin
              do_free = 1'b1;
            end
          end
          gsa_pkg::ACT_CHECK: begin
            fin = 1'b1;
            if (!hit) begin
              res_status = gsa_pkg::STAT_DEAD;
            end
          end
          gsa_pkg::ACT_ENQUEUE: begin
            fin = 1'b1;
            if (!hit) begin
              res_status = gsa_pkg::STAT_DEAD;
            end else if (rd_st == gsa_pkg::SLOT_QUEUED) begin
              res_status = gsa_pkg::STAT_OK;
            end else if (32'(fifo_depth_q) >= SLOT_COUNT) begin
              res_status = gsa_pkg::STAT_QFULL;
            end else begin
              slot_we      = 1'b1;
              slot_wdata   = {gsa_pkg::SLOT_QUEUED, rd_gen};
              list_we      = 1'b1;
              list_waddr   = {1'b1, fifo_depth_q[IW-1:0]};
              fifo_depth_d = fifo_depth_q + CW'(1);
            end
          end
          gsa_pkg::ACT_DRAIN: begin
            k_d   = '0;
            rel_d = '0;
            if (fifo_depth_q == '0) begin
              fin = 1'b1;
            end else begin
              state_d = gsa_pkg::S_DR_IDX;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      gsa_pkg::S_ALLOC_RD: begin
        // Revive the popped slot under its current generation.
        fin        = 1'b1;
        slot_we    = 1'b1;
        slot_wdata = {gsa_pkg::SLOT_ALIVE, rd_gen};
        live_d     = live_q + CW'(1);
        res_oid    = gsa_pkg::ID_W'(32'(idx_q) + 32'd1);
        res_ogen   = gsa_pkg::HGEN_W'(rd_gen);
      end
      gsa_pkg::S_DR_IDX: begin
        // Queue entry is in hand; fetch its slot if it lies in the used range.
        idx_d = list_rdata;
        if (32'(list_rdata) < 32'(slots_used_q)) begin
          slot_re    = 1'b1;
          slot_raddr = list_rdata;
          state_d    = gsa_pkg::S_DR_SLOT;
        end else begin
          step = 1'b1;
        end
      end
      gsa_pkg::S_DR_SLOT: begin
        // Only entries still queued free their slot; stale ones are skipped.
        if (rd_st == gsa_pkg::SLOT_QUEUED) begin
          do_free = 1'b1;
          rel_d   = rel_q + CW'(1);
        end
        step = 1'b1;
      end
      default: begin
        state_d = gsa_pkg::S_IDLE;
      end
    endcase

    // Free a slot: bump the generation and push the index on the free stack.
    if (do_free) begin
      slot_we    = 1'b1;
      slot_waddr = idx_q;
      slot_wdata = {gsa_pkg::SLOT_FREE, gen_next};
      if (32'(free_depth_q) < SLOT_COUNT) begin
        list_we      = 1'b1;
        list_waddr   = {1'b0, free_depth_q[IW-1:0]};
        list_wdata   = idx_q;
        free_depth_d = free_depth_q + CW'(1);
      end
      if (live_q != '0) begin
        live_d = live_q - CW'(1);
      end
    end

    // Advance the drain to the next queue entry or finish it.
    if (step) begin
      k_d = k_q + CW'(1);
      if (k_d == fifo_depth_q) begin
        fin          = 1'b1;
        fifo_depth_d = '0;
      end else begin
        list_re    = 1'b1;
        list_raddr = {1'b1, k_d[IW-1:0]};
        state_d    = gsa_pkg::S_DR_IDX;
      end
    end

    if (fin) begin
      state_d = gsa_pkg::S_IDLE;
    end

    // A finishing step waits, with no side effect, while the result register is full.
    stall = fin && !out_free;
    if (stall) begin
      state_d      = state_q;
      idx_d        = idx_q;
      free_depth_d = free_depth_q;
      slots_used_d = slots_used_q;
      fifo_depth_d = fifo_depth_q;
      live_d       = live_q;
      k_d          = k_q;
      rel_d        = rel_q;
      slot_we      = 1'b0;
      slot_re      = 1'b0;
      list_we      = 1'b0;
      list_re      = 1'b0;
    end

    // Result register; the released count is only reported by a drain.
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    if (fin && !stall) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'b000,
                     gsa_pkg::COUNT_W'(live_d),
                     (act_q == gsa_pkg::ACT_DRAIN) ? gsa_pkg::COUNT_W'(rel_d)
                                                   : gsa_pkg::COUNT_W'(0),
                     res_ogen,
                     res_oid,
                     res_status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  // Every used slot is either live or waiting on the free stack, except in the cycle
  // where a slot popped from the stack is being revived.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != gsa_pkg::S_ALLOC_RD) |->
      ((32'(live_q) + 32'(free_depth_q)) == 32'(slots_used_q)))
    else $error("live and free counts do not add up to the used slots");

  // The destroy queue never holds more entries than there are slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fifo_depth_q) <= SLOT_COUNT)
    else $error("destroy queue depth exceeds the slot count");

  // An accepted command is decoded in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == gsa_pkg::S_EXEC))
    else $error("accepted command was not decoded");

  // A result only appears after a command has been worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q != gsa_pkg::S_IDLE))
    else $error("result produced without a command");
`endif

endmodule

`default_nettype wire
